FILE: hw/rtl/m4inv_pkg.sv
// ---------------------------------------------------------------------------
// m4inv_pkg
// Types, constants and index tables shared by the 4x4 inverse block.
// ---------------------------------------------------------------------------
`default_nettype none

package m4inv_pkg;

    localparam int ELEM_W = 32;
    localparam int WIDE_W = 64;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FAC,
        S_ADJ,
        S_DET,
        S_DIVRD,
        S_DIVGO,
        S_DIVWAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        B_ELEM,
        B_FAC,
        B_ADJ
    } t_bsrc;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_accop;

    typedef enum logic [2:0] {
        POST_NONE,
        POST_FAC,
        POST_ADJ,
        POST_TMP,
        POST_DET
    } t_post;

    // cycles of one product step
    localparam logic [2:0] CYC_READ = 3'd0;
    localparam logic [2:0] CYC_MAG  = 3'd1;
    localparam logic [2:0] CYC_PLO  = 3'd2;
    localparam logic [2:0] CYC_PHI  = 3'd3;
    localparam logic [2:0] CYC_SUM  = 3'd4;
    localparam logic [2:0] CYC_SAT  = 3'd5;
    localparam logic [2:0] CYC_ACC  = 3'd6;

    typedef struct packed {
        logic       exec;
        logic [2:0] cyc;
        logic [3:0] a_idx;
        t_bsrc      b_src;
        logic [4:0] b_idx;
        t_accop     acc_op;
        t_post      post;
        logic       post_neg;
        logic [4:0] dst_idx;
        logic       load;
        logic [3:0] ld_idx;
        logic       div_start;
    } t_cmd;

    typedef struct packed {
        logic singular;
        logic div_done;
    } t_stat;

    function automatic logic [1:0] fac_row_a(input logic [1:0] k);
        return (k < 2'd2) ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [1:0] fac_row_b(input logic [1:0] k);
        return (k == 2'd3) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [1:0] fac_col_a(input logic [2:0] f);
        logic [1:0] r;
        case (f)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] fac_col_b(input logic [2:0] f);
        logic [1:0] r;
        case (f)
            3'd0:    r = 2'd3;
            3'd1:    r = 2'd3;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd3;
            3'd4:    r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // column of the first two rows used for term t of adjugate row i
    function automatic logic [1:0] adj_vec(input logic [1:0] i, input logic [1:0] t);
        return (t >= i) ? t + 2'd1 : t;
    endfunction

    function automatic logic [2:0] adj_fac(input logic [1:0] i, input logic [1:0] t);
        logic [2:0] r;
        case ({i, t})
            4'b00_00: r = 3'd0;
            4'b00_01: r = 3'd1;
            4'b00_10: r = 3'd2;
            4'b01_00: r = 3'd0;
            4'b01_01: r = 3'd3;
            4'b01_10: r = 3'd4;
            4'b10_00: r = 3'd1;
            4'b10_01: r = 3'd3;
            4'b10_10: r = 3'd5;
            4'b11_00: r = 3'd2;
            4'b11_01: r = 3'd4;
            default:  r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/m4inv_if.sv
// ---------------------------------------------------------------------------
// m4inv_if
// Valid/ready channels for matrix elements in and inverse elements out.
// ---------------------------------------------------------------------------
`default_nettype none

interface m4inv_in_if import m4inv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] in_element;

    modport source (output valid, output in_element, input ready);
    modport sink   (input valid, input in_element, output ready);
endinterface

interface m4inv_out_if import m4inv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] out_element;
    logic              out_last;
    logic              singular;

    modport source (output valid, output out_element, output out_last, output singular,
                    input ready);
    modport sink   (input valid, input out_element, input out_last, input singular,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/matrix4x4_inverse.sv
// ---------------------------------------------------------------------------
// matrix4x4_inverse
// Streaming 4x4 matrix inverse by cofactors, signed fixed point.
// ---------------------------------------------------------------------------
// Sixteen elements go in row-major and sixteen inverse elements come out
// row-major, the last one flagged; singular is set on all of them (and the
// elements are zero) when the determinant is zero. One matrix at a time: the
// load, then 100 product steps on the shared 32x32 multiplier
// (sub-determinants, adjugate, determinant), then per result element a
// setup and a run of the bit-serial divider (skipped when singular) and one
// output transaction; input is held off until the last element has gone out.
`default_nettype none

module matrix4x4_inverse import m4inv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    m4inv_in_if.sink    i_in,
    m4inv_out_if.source o_out
);

    t_cmd              cmd;
    t_stat             stat;
    logic [ELEM_W-1:0] result;
    logic              in_ready;
    logic              out_valid;
    logic              out_last;

    m4inv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_last  (out_last),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    m4inv_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_element (i_in.in_element),
        .o_stat    (stat),
        .o_result  (result)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.out_element = result;
    assign o_out.out_last    = out_last;
    assign o_out.singular    = stat.singular;

endmodule

`default_nettype wire

FILE: hw/rtl/m4inv_ctrl.sv
// ---------------------------------------------------------------------------
// m4inv_ctrl
// Sequencer: load, sub-determinants, adjugate, determinant, divide, output.
// ---------------------------------------------------------------------------
`default_nettype none

module m4inv_ctrl import m4inv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire logic  i_out_ready,
    output logic       o_out_valid,
    output logic       o_out_last,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_cyc, n_cyc;
    logic [2:0] r_f, n_f;
    logic [1:0] r_k, n_k;
    logic [1:0] r_t, n_t;
    logic [3:0] r_n, n_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_cyc   <= '0;
            r_f     <= '0;
            r_k     <= '0;
            r_t     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cyc   <= n_cyc;
            r_f     <= n_f;
            r_k     <= n_k;
            r_t     <= n_t;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cyc       = r_cyc;
        n_f         = r_f;
        n_k         = r_k;
        n_t         = r_t;
        n_n         = r_n;
        o_cmd       = '0;
        o_cmd.cyc   = r_cyc;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = (r_n == 4'd15);
        case (r_state)
            S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_idx = r_cnt;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_state = S_FAC;
                    end
                end
            end
            S_FAC: begin
                o_cmd.exec  = 1'b1;
                o_cmd.b_src = B_ELEM;
                if (r_t == 2'd0) begin
                    o_cmd.a_idx  = {fac_row_a(r_k), fac_col_a(r_f)};
                    o_cmd.b_idx  = {1'b0, fac_row_b(r_k), fac_col_b(r_f)};
                    o_cmd.acc_op = ACC_LOAD;
                end else begin
                    o_cmd.a_idx   = {fac_row_b(r_k), fac_col_a(r_f)};
                    o_cmd.b_idx   = {1'b0, fac_row_a(r_k), fac_col_b(r_f)};
                    o_cmd.acc_op  = ACC_SUB;
                    o_cmd.post    = POST_FAC;
                    o_cmd.dst_idx = {r_f, r_k};
                end
                if (r_cyc == CYC_ACC) begin
                    n_cyc = '0;
                    if (r_t == 2'd1) begin
                        n_t = '0;
                        if (r_k == 2'd3) begin
                            n_k = '0;
                            if (r_f == 3'd5) begin
                                n_f     = '0;
                                n_state = S_ADJ;
                            end else begin
                                n_f = r_f + 3'd1;
                            end
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end else begin
                        n_t = r_t + 2'd1;
                    end
                end else begin
                    n_cyc = r_cyc + 3'd1;
                end
            end
            S_ADJ: begin
                o_cmd.exec     = 1'b1;
                o_cmd.b_src    = B_FAC;
                o_cmd.a_idx    = {((r_k == 2'd0) ? 2'd1 : 2'd0), adj_vec(r_f[1:0], r_t)};
                o_cmd.b_idx    = {adj_fac(r_f[1:0], r_t), r_k};
                o_cmd.dst_idx  = {1'b0, r_f[1:0], r_k};
                o_cmd.post_neg = r_f[0] ^ r_k[0];
                case (r_t)
                    2'd0:    o_cmd.acc_op = ACC_LOAD;
                    2'd1:    o_cmd.acc_op = ACC_SUB;
                    default: begin
                        o_cmd.acc_op = ACC_ADD;
                        o_cmd.post   = POST_ADJ;
                    end
                endcase
                if (r_cyc == CYC_ACC) begin
                    n_cyc = '0;
                    if (r_t == 2'd2) begin
                        n_t = '0;
                        if (r_k == 2'd3) begin
                            n_k = '0;
                            if (r_f == 3'd3) begin
                                n_f     = '0;
                                n_state = S_DET;
                            end else begin
                                n_f = r_f + 3'd1;
                            end
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end else begin
                        n_t = r_t + 2'd1;
                    end
                end else begin
                    n_cyc = r_cyc + 3'd1;
                end
            end
            S_DET: begin
                o_cmd.exec  = 1'b1;
                o_cmd.b_src = B_ADJ;
                o_cmd.a_idx = {2'd0, r_t};
                o_cmd.b_idx = {1'b0, r_t, 2'd0};
                // det = (p0 + p1) + (p2 + p3)
                case (r_t)
                    2'd0:    o_cmd.acc_op = ACC_LOAD;
                    2'd1:    begin
                        o_cmd.acc_op = ACC_ADD;
                        o_cmd.post   = POST_TMP;
                    end
                    2'd2:    o_cmd.acc_op = ACC_LOAD;
                    default: begin
                        o_cmd.acc_op = ACC_ADD;
                        o_cmd.post   = POST_DET;
                    end
                endcase
                if (r_cyc == CYC_ACC) begin
                    n_cyc = '0;
                    n_t   = r_t + 2'd1;
                    if (r_t == 2'd3) begin
                        n_n     = '0;
                        n_state = S_DIVRD;
                    end
                end else begin
                    n_cyc = r_cyc + 3'd1;
                end
            end
            S_DIVRD: begin
                o_cmd.b_idx = {1'b0, r_n};
                n_state     = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.b_idx     = {1'b0, r_n};
                o_cmd.div_start = 1'b1;
                n_state         = i_stat.singular ? S_OUT : S_DIVWAIT;
            end
            S_DIVWAIT: begin
                o_cmd.b_idx = {1'b0, r_n};
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_n == 4'd15) begin
                        n_n     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_n     = r_n + 4'd1;
                        n_state = S_DIVRD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/m4inv_div.sv
// ---------------------------------------------------------------------------
// m4inv_div
// Restoring divider, one quotient bit per cycle, quotient capped at 2^32.
// ---------------------------------------------------------------------------
`default_nettype none

module m4inv_div import m4inv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WIDE_W-1:0] i_num,
    input  wire logic [WIDE_W-1:0] i_den,
    output logic                   o_done,
    output logic [ELEM_W:0]        o_quot
);

    localparam int NW = WIDE_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [ELEM_W:0] QCAP = {1'b1, {ELEM_W{1'b0}}};

    logic [NW-1:0]     r_num;
    logic [WIDE_W-1:0] r_den;
    logic [WIDE_W-1:0] r_rem;
    logic [ELEM_W:0]   r_q;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WIDE_W:0]   rr;
    logic              ge;
    logic [ELEM_W+1:0] q2;

    always_comb begin
        rr = {r_rem, r_num[NW-1]};
        ge = (rr >= {1'b0, r_den});
        q2 = {r_q, ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= ge ? WIDE_W'(rr - {1'b0, r_den}) : rr[WIDE_W-1:0];
            r_q   <= (q2 > {1'b0, QCAP}) ? QCAP : q2[ELEM_W:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/m4inv_dp.sv
// ---------------------------------------------------------------------------
// m4inv_dp
// Datapath: element store, shared multiplier, accumulator, factor and
// adjugate stores, determinant and scaling divider.
// ---------------------------------------------------------------------------
`default_nettype none

module m4inv_dp import m4inv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [ELEM_W-1:0] i_element,
    output t_stat                  o_stat,
    output logic [ELEM_W-1:0]      o_result
);

    localparam logic [WIDE_W-1:0] POS_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic [WIDE_W-1:0] NEG_MAX = {1'b1, {(WIDE_W-2){1'b0}}, 1'b1};
    localparam int PW = ELEM_W + WIDE_W;

    function automatic logic [WIDE_W-1:0] sat_add(input logic [WIDE_W-1:0] a,
                                                   input logic [WIDE_W-1:0] b);
        logic [WIDE_W:0] s;
        logic [WIDE_W-1:0] r;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (!s[WIDE_W] && s[WIDE_W-1]) begin
            r = POS_MAX;
        end else if (s[WIDE_W] && (!s[WIDE_W-1] || s[WIDE_W-2:0] == '0)) begin
            r = NEG_MAX;
        end else begin
            r = s[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WIDE_W-1:0] mag64(input logic [WIDE_W-1:0] a);
        return a[WIDE_W-1] ? WIDE_W'(~a + 1'b1) : a;
    endfunction

    logic [ELEM_W-1:0] r_mat [0:15];
    logic [WIDE_W-1:0] r_fac [0:23];
    logic [WIDE_W-1:0] r_adj [0:15];

    logic [ELEM_W-1:0] r_ra, r_rb;
    logic [WIDE_W-1:0] r_rf, r_rd;
    logic [ELEM_W-1:0] r_x;
    logic [WIDE_W-1:0] r_y;
    logic              r_neg;
    logic [WIDE_W-1:0] r_pp;
    logic [PW-1:0]     r_p;
    logic [WIDE_W-1:0] r_term;
    logic [WIDE_W-1:0] r_acc;
    logic [WIDE_W-1:0] r_tmp;
    logic [WIDE_W-1:0] r_det;
    logic              r_dneg;
    logic [ELEM_W-1:0] r_result;

    logic [WIDE_W-1:0] b_val;
    logic [WIDE_W-1:0] m_val;
    logic              m_ovf;
    logic [WIDE_W-1:0] n_acc;
    logic              singular;
    logic              div_done;
    logic [ELEM_W:0]   div_quot;

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mat[i_cmd.ld_idx] <= i_element;
        end
        r_ra <= r_mat[i_cmd.a_idx];
        r_rb <= r_mat[i_cmd.b_idx[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.cyc == CYC_ACC && i_cmd.post == POST_FAC) begin
            r_fac[i_cmd.dst_idx] <= n_acc;
        end
        if (i_cmd.b_idx < 5'd24) begin
            r_rf <= r_fac[i_cmd.b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && i_cmd.cyc == CYC_ACC && i_cmd.post == POST_ADJ) begin
            r_adj[i_cmd.dst_idx[3:0]] <= i_cmd.post_neg ? WIDE_W'(~n_acc + 1'b1) : n_acc;
        end
        r_rd <= r_adj[i_cmd.b_idx[3:0]];
    end

    always_comb begin
        case (i_cmd.b_src)
            B_ELEM:  b_val = {{(WIDE_W-ELEM_W){r_rb[ELEM_W-1]}}, r_rb};
            B_FAC:   b_val = r_rf;
            default: b_val = r_rd;
        endcase
        m_ovf = |(r_p >> (WIDE_W + FRAC_BITS));
        m_val = WIDE_W'(r_p >> FRAC_BITS);
        if (m_ovf || m_val[WIDE_W-1]) begin
            m_val = POS_MAX;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: n_acc = r_term;
            ACC_SUB:  n_acc = sat_add(r_acc, WIDE_W'(~r_term + 1'b1));
            default:  n_acc = sat_add(r_acc, r_term);
        endcase
    end

    // product step: magnitudes, two 32x32 partial products, sum, saturate, accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (i_cmd.cyc)
                CYC_MAG: begin
                    r_x   <= r_ra[ELEM_W-1] ? ELEM_W'(~r_ra + 1'b1) : r_ra;
                    r_y   <= mag64(b_val);
                    r_neg <= r_ra[ELEM_W-1] ^ b_val[WIDE_W-1];
                end
                CYC_PLO: r_pp <= {{ELEM_W{1'b0}}, r_x} *
                                 {{ELEM_W{1'b0}}, r_y[ELEM_W-1:0]};
                CYC_PHI: begin
                    r_p  <= {{(PW-WIDE_W){1'b0}}, r_pp};
                    r_pp <= {{ELEM_W{1'b0}}, r_x} *
                            {{ELEM_W{1'b0}}, r_y[WIDE_W-1:ELEM_W]};
                end
                CYC_SUM: r_p <= r_p + {r_pp, {ELEM_W{1'b0}}};
                CYC_SAT: r_term <= r_neg ? WIDE_W'(~m_val + 1'b1) : m_val;
                CYC_ACC: begin
                    r_acc <= n_acc;
                    if (i_cmd.post == POST_TMP) begin
                        r_tmp <= n_acc;
                    end
                    if (i_cmd.post == POST_DET) begin
                        r_det <= sat_add(n_acc, r_tmp);
                    end
                end
                default: ;
            endcase
        end
    end

    assign singular = (r_det == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dneg <= r_rd[WIDE_W-1] ^ r_det[WIDE_W-1];
            if (singular) begin
                r_result <= '0;
            end
        end else if (div_done) begin
            if (r_dneg) begin
                r_result <= (div_quot >= {2'b01, {(ELEM_W-1){1'b0}}})
                    ? {1'b1, {(ELEM_W-1){1'b0}}} : ELEM_W'(~div_quot + 1'b1);
            end else begin
                r_result <= (div_quot > {2'b00, {(ELEM_W-1){1'b1}}})
                    ? {1'b0, {(ELEM_W-1){1'b1}}} : div_quot[ELEM_W-1:0];
            end
        end
    end

    m4inv_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start && !singular),
        .i_num   (mag64(r_rd)),
        .i_den   (mag64(r_det)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_stat.singular = singular;
    assign o_stat.div_done = div_done;
    assign o_result        = r_result;

endmodule

`default_nettype wire

FILE: verif/m4inv_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m4inv_checker
// Watches both channels of the 4x4 inverse block, keeps its own copy of the
// loaded matrix, computes the expected inverse elements in fixed point and
// compares every output transaction against the oldest expected element.
// ---------------------------------------------------------------------------
`default_nettype none

module m4inv_checker import m4inv_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    m4inv_in_if       i_in,
    m4inv_out_if      i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_matrices,
    output int        o_singular
);

    typedef struct {
        logic [ELEM_W-1:0] elem;
        logic              last;
        logic              sing;
    } t_inv_elem;

    localparam longint WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // lower-row pairs and column pairs of the 2x2 sub-determinants
    localparam int ROW_A[4] = '{2, 2, 1, 1};
    localparam int ROW_B[4] = '{3, 3, 3, 2};
    localparam int COL_A[6] = '{2, 1, 1, 0, 0, 0};
    localparam int COL_B[6] = '{3, 3, 2, 3, 2, 1};
    localparam int TERM_COL[4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
    localparam int TERM_FAC[4][3] = '{'{0, 1, 2}, '{0, 3, 4}, '{1, 3, 5}, '{2, 4, 5}};

    longint    mat [16];
    int        load_idx;
    t_inv_elem inverse_q[$];

    function automatic longint sat_sum(input longint a, input longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, WMAX})) return WMAX;
        if (s < -$signed({1'b0, WMAX})) return -WMAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        logic [63:0]  x, y, m;
        logic [127:0] p;
        x = (a < 0) ? 64'(-a) : 64'(a);
        y = (b < 0) ? 64'(-b) : 64'(b);
        p = 128'(x) * 128'(y);
        if ((p >> (64 + FRAC_BITS)) != 0) begin
            m = 64'(WMAX);
        end else begin
            m = 64'(p >> FRAC_BITS);
            if (m > 64'(WMAX)) m = 64'(WMAX);
        end
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [ELEM_W-1:0] fx_scale(input longint adj, input longint det);
        logic [127:0] n, q;
        logic [63:0]  d;
        n = 128'((adj < 0) ? 64'(-adj) : 64'(adj)) << FRAC_BITS;
        d = (det < 0) ? 64'(-det) : 64'(det);
        q = n / 128'(d);
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        if ((adj < 0) != (det < 0)) begin
            if (q >= 128'h8000_0000) return 32'h8000_0000;
            return 32'(-longint'(q[63:0]));
        end
        if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic longint at(input int r, input int c);
        return mat[r * 4 + c];
    endfunction

    task automatic predict_inverse();
        longint    fac [6][4];
        longint    adj [4][4];
        longint    t0, t1, t2, v, det;
        t_inv_elem e;
        for (int f = 0; f < 6; f++)
            for (int k = 0; k < 4; k++)
                fac[f][k] = sat_sum(fx_mul(at(ROW_A[k], COL_A[f]), at(ROW_B[k], COL_B[f])),
                                    -fx_mul(at(ROW_B[k], COL_A[f]), at(ROW_A[k], COL_B[f])));
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++) begin
                // term vectors come from row 1 for k==0, row 0 otherwise
                t0 = fx_mul(at(k == 0 ? 1 : 0, TERM_COL[i][0]), fac[TERM_FAC[i][0]][k]);
                t1 = fx_mul(at(k == 0 ? 1 : 0, TERM_COL[i][1]), fac[TERM_FAC[i][1]][k]);
                t2 = fx_mul(at(k == 0 ? 1 : 0, TERM_COL[i][2]), fac[TERM_FAC[i][2]][k]);
                v = sat_sum(sat_sum(t0, -t1), t2);
                adj[i][k] = ((i + k) % 2 == 1) ? -v : v;
            end
        det = sat_sum(sat_sum(fx_mul(at(0, 0), adj[0][0]), fx_mul(at(0, 1), adj[1][0])),
                      sat_sum(fx_mul(at(0, 2), adj[2][0]), fx_mul(at(0, 3), adj[3][0])));
        for (int i = 0; i < 16; i++) begin
            e.elem = (det == 0) ? '0 : fx_scale(adj[i / 4][i % 4], det);
            e.last = (i == 15);
            e.sing = (det == 0);
            inverse_q.push_back(e);
        end
        o_matrices++;
        if (det == 0) o_singular++;
    endtask

    task automatic report(input string msg);
        $display("%0t checker: %s", $realtime, msg);
        o_errors++;
    endtask

    initial begin
        o_errors   = 0;
        o_matrices = 0;
        o_singular = 0;
        load_idx   = 0;
    end

    assign o_pending = inverse_q.size();

    always @(posedge i_clk) begin
        t_inv_elem e;
        if (!i_rst_n) begin
            load_idx = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (inverse_q.size() == 0) begin
                    report($sformatf("unexpected output transaction %h", i_out.out_element));
                end else begin
                    e = inverse_q.pop_front();
                    if (i_out.out_element !== e.elem)
                        report($sformatf("element got %h exp %h", i_out.out_element, e.elem));
                    if (i_out.out_last !== e.last)
                        report($sformatf("last got %b exp %b", i_out.out_last, e.last));
                    if (i_out.singular !== e.sing)
                        report($sformatf("singular got %b exp %b", i_out.singular, e.sing));
                end
            end
            if (i_in.valid && i_in.ready) begin
                mat[load_idx] = longint'($signed(i_in.in_element));
                load_idx = (load_idx + 1) % 16;
                if (load_idx == 0) predict_inverse();
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the streaming 4x4 inverse: directed identity and singular
// extreme matrices, then random matrices of several kinds under varying
// backpressure; checking is done by m4inv_checker.
// ---------------------------------------------------------------------------
`default_nettype none

module tb import m4inv_pkg::*; ();

    localparam int DRAIN_CYCLES = 2400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int snd_idle_pct;
    int rcv_idle_pct;
    int rcv_hold;
    int errors, pending, matrices, singulars;

    m4inv_in_if  in_ch ();
    m4inv_out_if out_ch ();

    matrix4x4_inverse #(.FRAC_BITS(16)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    m4inv_checker #(.FRAC_BITS(16)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_matrices (matrices),
        .o_singular (singulars)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end

    // receiver: random idling plus an optional long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rcv_hold > 0) begin
                rcv_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_elem(input logic [ELEM_W-1:0] x);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_element <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_matrix(input logic [ELEM_W-1:0] m [16]);
        for (int i = 0; i < 16; i++) send_elem(m[i]);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] rand_fx(input int lo, input int hi);
        int v;
        v = $urandom_range(0, hi - lo) + lo;
        return 32'(v);
    endfunction

    task automatic send_random_matrix();
        logic [ELEM_W-1:0] m [16];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++) begin
            if (kind < 5) begin
                // well-conditioned: strong diagonal, small off-diagonal
                m[i] = (i % 5 == 0) ? rand_fx(32'h0001_0000, 32'h0008_0000)
                                    : rand_fx(-32'h0000_8000, 32'h0000_8000);
                if (i % 5 == 0 && $urandom_range(0, 1)) m[i] = -m[i];
            end else if (kind < 7) begin
                m[i] = 32'($signed($urandom_range(0, 8)) - 4) << 16;
            end else if (kind < 9) begin
                m[i] = $urandom();
            end else begin
                m[i] = (i >= 12) ? m[i - 4] : $urandom();
            end
        end
        send_matrix(m);
    endtask

    initial begin
        logic [ELEM_W-1:0] m [16];
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_element <= '0;
        snd_idle_pct = 31;
        rcv_idle_pct = 87;
        rcv_hold     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : '0;
        send_matrix(m);
        // extremes with equal lower rows: singular
        m = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_matrix(m);
        wait_drained();

        repeat (3) send_random_matrix();
        wait_drained();

        snd_idle_pct = 87;
        rcv_idle_pct = 31;
        repeat (3) send_random_matrix();
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random_matrix();
        // long output hold-off while the next matrix is offered
        rcv_hold = 3000;
        send_random_matrix();

        for (int i = 0; i < 2 * DRAIN_CYCLES && pending != 0; i++) @(posedge i_clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d matrices inverted (%0d singular) under mixed backpressure",
                 matrices, singulars);
        if (errors == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/m4inv_pkg.sv
hw/rtl/m4inv_if.sv
hw/rtl/m4inv_ctrl.sv
hw/rtl/m4inv_div.sv
hw/rtl/m4inv_dp.sv
hw/rtl/matrix4x4_inverse.sv
verif/m4inv_checker.sv
verif/tb.sv
